// File: rtl/pooled_cursor_list_manager_defines.svh
// Assertion macros for the pooled cursor list manager.
`ifndef POOLED_CURSOR_LIST_MANAGER_DEFINES_SVH
`define POOLED_CURSOR_LIST_MANAGER_DEFINES_SVH
`ifndef SYNTH
`define PLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PLC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/plc_pkg.sv
// Shared constants, state codes and types of the pooled cursor list manager.
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;
    localparam int NODE_COUNT = 64;
    localparam int NUM_LISTS  = 8;
    localparam int ITEM_W     = 32;
    localparam int IDX_W      = $clog2(NODE_COUNT);
    localparam int PTR_W      = IDX_W + 1;
    localparam int LIST_W     = $clog2(NUM_LISTS);
    localparam int LEN_W      = PTR_W;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODE_COUNT);

    localparam logic [3:0] CMD_CREATE  = 4'd0;
    localparam logic [3:0] CMD_COUNT   = 4'd1;
    localparam logic [3:0] CMD_FIRST   = 4'd2;
    localparam logic [3:0] CMD_LAST    = 4'd3;
    localparam logic [3:0] CMD_NEXT    = 4'd4;
    localparam logic [3:0] CMD_PREV    = 4'd5;
    localparam logic [3:0] CMD_CURRENT = 4'd6;
    localparam logic [3:0] CMD_INS_AFT = 4'd7;
    localparam logic [3:0] CMD_INS_BEF = 4'd8;
    localparam logic [3:0] CMD_APPEND  = 4'd9;
    localparam logic [3:0] CMD_PREPEND = 4'd10;
    localparam logic [3:0] CMD_REMOVE  = 4'd11;
    localparam logic [3:0] CMD_TRIM    = 4'd12;
    localparam logic [3:0] CMD_CONCAT  = 4'd13;
    localparam logic [3:0] CMD_FREE    = 4'd14;
    localparam logic [3:0] CMD_SEARCH  = 4'd15;

    localparam logic [1:0] EDGE_START  = 2'd0;
    localparam logic [1:0] EDGE_END    = 2'd1;
    localparam logic [1:0] EDGE_INSIDE = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FAIL = 2'd2;

    localparam int SW = 5;
    localparam logic [SW-1:0] S_IDLE   = 5'd0;
    localparam logic [SW-1:0] S_DEC    = 5'd1;
    localparam logic [SW-1:0] S_BAD    = 5'd2;
    localparam logic [SW-1:0] S_CREATE = 5'd3;
    localparam logic [SW-1:0] S_FL     = 5'd4;
    localparam logic [SW-1:0] S_VAL    = 5'd5;
    localparam logic [SW-1:0] S_CUR    = 5'd6;
    localparam logic [SW-1:0] S_STEP0  = 5'd7;
    localparam logic [SW-1:0] S_STEP1  = 5'd8;
    localparam logic [SW-1:0] S_STEP2  = 5'd9;
    localparam logic [SW-1:0] S_INS0   = 5'd10;
    localparam logic [SW-1:0] S_INS1   = 5'd11;
    localparam logic [SW-1:0] S_INS2   = 5'd12;
    localparam logic [SW-1:0] S_INS3   = 5'd13;
    localparam logic [SW-1:0] S_RM0    = 5'd14;
    localparam logic [SW-1:0] S_RM1    = 5'd15;
    localparam logic [SW-1:0] S_RM2    = 5'd16;
    localparam logic [SW-1:0] S_CAT0   = 5'd17;
    localparam logic [SW-1:0] S_CAT1   = 5'd18;
    localparam logic [SW-1:0] S_FR0    = 5'd19;
    localparam logic [SW-1:0] S_FR1    = 5'd20;
    localparam logic [SW-1:0] S_FR2    = 5'd21;
    localparam logic [SW-1:0] S_FR3    = 5'd22;
    localparam logic [SW-1:0] S_SR0    = 5'd23;
    localparam logic [SW-1:0] S_SR1    = 5'd24;
    localparam logic [SW-1:0] S_SR2    = 5'd25;
    localparam logic [SW-1:0] S_WB     = 5'd26;
    localparam logic [SW-1:0] S_OUT    = 5'd27;

    typedef struct packed {
        logic [3:0] cmd;
        logic       ok;
        logic       c_nil;
        logic       f_nil;
        logic       z_nil;
        logic       n_nil;
        logic       e_start;
        logic       e_end;
        logic       full;
        logic       o_bad;
        logic       hit;
        logic       out_free;
    } plc_flags_t;
endpackage
`default_nettype wire

// File: rtl/plc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module plc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/plc_ctrl.sv
// Command sequencer of the pooled cursor list manager.
`timescale 1ns / 1ps
`default_nettype none
module plc_ctrl
    import plc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_fire,
    input  wire plc_flags_t flags,
    output logic [SW-1:0]   state
);
    logic [SW-1:0] state_reg, state_next;
    logic          is_next, step_in, fl_nil, rm_nil, ins_rd;

    assign state   = state_reg;
    assign is_next = (flags.cmd == CMD_NEXT);
    assign step_in = (is_next && flags.e_start) || (!is_next && flags.e_end);
    assign fl_nil  = (flags.cmd == CMD_FIRST) ? flags.f_nil : flags.z_nil;
    assign rm_nil  = (flags.cmd == CMD_REMOVE) ? flags.c_nil : flags.z_nil;
    assign ins_rd  = ((flags.cmd == CMD_INS_AFT) || (flags.cmd == CMD_INS_BEF)) && !flags.c_nil;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_fire) state_next = S_DEC;
            S_DEC:
            begin
                if (flags.cmd == CMD_CREATE)
                    state_next = S_CREATE;
                else if (!flags.ok)
                    state_next = S_BAD;
                else
                begin
                    unique case (flags.cmd)
                        CMD_FIRST, CMD_LAST:  state_next = S_FL;
                        CMD_NEXT, CMD_PREV:   state_next = S_STEP0;
                        CMD_CURRENT:          state_next = S_CUR;
                        CMD_INS_AFT, CMD_INS_BEF, CMD_APPEND, CMD_PREPEND:
                                              state_next = S_INS0;
                        CMD_REMOVE, CMD_TRIM: state_next = S_RM0;
                        CMD_CONCAT:           state_next = S_CAT0;
                        CMD_FREE:             state_next = S_FR0;
                        CMD_SEARCH:           state_next = S_SR0;
                        default:              state_next = S_WB;
                    endcase
                end
            end
            S_BAD, S_CREATE: state_next = S_OUT;
            S_FL:    state_next = fl_nil ? S_WB : S_VAL;
            S_VAL:   state_next = S_WB;
            S_CUR:   state_next = flags.c_nil ? S_WB : S_VAL;
            S_STEP0:
            begin
                if (flags.f_nil)
                    state_next = S_WB;
                else if (flags.c_nil)
                    state_next = step_in ? S_STEP2 : S_WB;
                else
                    state_next = S_STEP1;
            end
            S_STEP1: state_next = S_STEP2;
            S_STEP2: state_next = flags.n_nil ? S_WB : S_VAL;
            S_INS0:
            begin
                if (flags.full)
                    state_next = S_WB;
                else
                    state_next = ins_rd ? S_INS1 : S_INS2;
            end
            S_INS1:  state_next = S_INS2;
            S_INS2:  state_next = S_INS3;
            S_INS3:  state_next = S_WB;
            S_RM0:   state_next = rm_nil ? S_WB : S_RM1;
            S_RM1:   state_next = S_RM2;
            S_RM2:   state_next = S_WB;
            S_CAT0:  state_next = flags.o_bad ? S_WB : S_CAT1;
            S_CAT1:  state_next = S_WB;
            S_FR0:   state_next = S_FR1;
            S_FR1:   state_next = flags.n_nil ? S_FR3 : S_FR2;
            S_FR2:   state_next = S_FR1;
            S_FR3:   state_next = S_WB;
            S_SR0:   state_next = S_SR1;
            S_SR1:   state_next = flags.n_nil ? S_WB : S_SR2;
            S_SR2:   state_next = flags.hit ? S_WB : S_SR1;
            S_WB:    state_next = S_OUT;
            S_OUT:   if (flags.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// File: rtl/plc_dp.sv
// Datapath: list table, node pool memories, free-node search and result register.
`timescale 1ns / 1ps
`default_nettype none
module plc_dp
    import plc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [SW-1:0] state,
    input  wire logic          s_tvalid,
    input  wire logic [79:0]   s_tdata,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [47:0]        m_tdata,
    output plc_flags_t         flags
);
    // list table
    logic [PTR_W-1:0]  lf_reg [NUM_LISTS];
    logic [PTR_W-1:0]  lz_reg [NUM_LISTS];
    logic [PTR_W-1:0]  lc_reg [NUM_LISTS];
    logic [1:0]        le_reg [NUM_LISTS];
    logic [LEN_W-1:0]  ll_reg [NUM_LISTS];
    logic [NUM_LISTS-1:0] open_reg;
    logic [NODE_COUNT-1:0] busy_reg;
    logic [PTR_W-1:0]  nn_reg, nn_next;

    // working copy of the selected list and command
    logic [3:0]        cmd_reg;
    logic [LIST_W-1:0] l_reg, o_reg;
    logic [ITEM_W-1:0] v_reg, key_reg, item_reg;
    logic [PTR_W-1:0]  f_reg, z_reg, c_reg, n_reg, a_reg, b_reg, of_reg, oz_reg;
    logic [1:0]        e_reg, st_reg;
    logic [LEN_W-1:0]  len_reg, olen_reg;
    logic [LIST_W-1:0] hd_reg;
    logic              mv_reg;
    logic [47:0]       md_reg;

    logic [LIST_W-1:0] row_addr, free_list;
    logic              any_free, s_fire, out_free;
    logic [PTR_W-1:0]  fl_n, rd_ptr, new_f, new_z;
    logic              a_nil, b_nil;

    logic              v_we, n_we, p_we;
    logic [IDX_W-1:0]  v_wa, n_wa, p_wa;
    logic [PTR_W-1:0]  n_wd, p_wd;
    logic [ITEM_W-1:0] v_rd;
    logic [PTR_W-1:0]  n_rd, p_rd;

    assign s_tready = (state == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign row_addr = (state == S_CAT0) ? o_reg : s_tdata[6:4];
    assign fl_n     = (cmd_reg == CMD_FIRST) ? f_reg : z_reg;
    assign a_nil    = a_reg[IDX_W];
    assign b_nil    = b_reg[IDX_W];
    assign new_f    = a_nil ? b_reg : f_reg;
    assign new_z    = b_nil ? a_reg : z_reg;

    always_comb
    begin
        nn_next = NIL;
        for (int i = NODE_COUNT - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
                nn_next = PTR_W'(i);
        end
    end

    always_comb
    begin
        any_free  = 1'b0;
        free_list = '0;
        for (int k = NUM_LISTS - 1; k >= 0; k--)
        begin
            if (!open_reg[k])
            begin
                any_free  = 1'b1;
                free_list = LIST_W'(k);
            end
        end
    end

    always_comb
    begin
        flags.cmd      = cmd_reg;
        flags.ok       = open_reg[l_reg];
        flags.c_nil    = c_reg[IDX_W];
        flags.f_nil    = f_reg[IDX_W];
        flags.z_nil    = z_reg[IDX_W];
        flags.n_nil    = n_reg[IDX_W];
        flags.e_start  = (e_reg == EDGE_START);
        flags.e_end    = (e_reg == EDGE_END);
        flags.full     = nn_reg[IDX_W];
        flags.o_bad    = (o_reg == l_reg) || !open_reg[o_reg];
        flags.hit      = (v_rd == key_reg);
        flags.out_free = out_free;
    end

    always_comb
    begin
        unique case (state)
            S_FL:                    rd_ptr = fl_n;
            S_CUR, S_STEP0, S_INS0:  rd_ptr = c_reg;
            S_RM0:                   rd_ptr = (cmd_reg == CMD_REMOVE) ? c_reg : z_reg;
            default:                 rd_ptr = n_reg;
        endcase
    end

    always_comb
    begin
        v_we = 1'b0; v_wa = n_reg[IDX_W-1:0];
        n_we = 1'b0; n_wa = n_reg[IDX_W-1:0]; n_wd = b_reg;
        p_we = 1'b0; p_wa = n_reg[IDX_W-1:0]; p_wd = a_reg;
        unique case (state)
            S_INS2:
            begin
                v_we = 1'b1;
                n_we = 1'b1;
                p_we = 1'b1;
            end
            S_INS3:
            begin
                n_we = !a_nil; n_wa = a_reg[IDX_W-1:0]; n_wd = n_reg;
                p_we = !b_nil; p_wa = b_reg[IDX_W-1:0]; p_wd = n_reg;
            end
            S_RM2:
            begin
                n_we = !a_nil; n_wa = a_reg[IDX_W-1:0]; n_wd = b_reg;
                p_we = !b_nil; p_wa = b_reg[IDX_W-1:0]; p_wd = a_reg;
            end
            S_CAT1:
            begin
                n_we = !of_reg[IDX_W] && !z_reg[IDX_W];
                n_wa = z_reg[IDX_W-1:0]; n_wd = of_reg;
                p_we = n_we;
                p_wa = of_reg[IDX_W-1:0]; p_wd = z_reg;
            end
            default: ;
        endcase
    end

    plc_ram #(.WIDTH(ITEM_W), .DEPTH(NODE_COUNT)) u_val (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_reg),
        .raddr(rd_ptr[IDX_W-1:0]), .rdata(v_rd)
    );
    plc_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_next (
        .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd),
        .raddr(rd_ptr[IDX_W-1:0]), .rdata(n_rd)
    );
    plc_ram #(.WIDTH(PTR_W), .DEPTH(NODE_COUNT)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd),
        .raddr(rd_ptr[IDX_W-1:0]), .rdata(p_rd)
    );

    // control state: list table, open and busy marks, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_LISTS; k++)
            begin
                lf_reg[k] <= NIL;
                lz_reg[k] <= NIL;
                lc_reg[k] <= NIL;
                le_reg[k] <= EDGE_START;
                ll_reg[k] <= '0;
            end
            open_reg <= '0;
            busy_reg <= '0;
            nn_reg   <= '0;
            mv_reg   <= 1'b0;
        end
        else
        begin
            nn_reg <= nn_next;
            if (state == S_OUT && out_free)
                mv_reg <= 1'b1;
            else if (m_tready)
                mv_reg <= 1'b0;
            unique case (state)
                S_CREATE:
                begin
                    if (any_free)
                    begin
                        open_reg[free_list] <= 1'b1;
                        lf_reg[free_list]   <= NIL;
                        lz_reg[free_list]   <= NIL;
                        lc_reg[free_list]   <= NIL;
                        le_reg[free_list]   <= EDGE_START;
                        ll_reg[free_list]   <= '0;
                    end
                end
                S_INS2: busy_reg[n_reg[IDX_W-1:0]] <= 1'b1;
                S_RM2:  busy_reg[n_reg[IDX_W-1:0]] <= 1'b0;
                S_FR1:  if (!n_reg[IDX_W]) busy_reg[n_reg[IDX_W-1:0]] <= 1'b0;
                S_FR3:  open_reg[l_reg] <= 1'b0;
                S_CAT1:
                begin
                    open_reg[o_reg] <= 1'b0;
                    lf_reg[o_reg]   <= NIL;
                    lz_reg[o_reg]   <= NIL;
                    lc_reg[o_reg]   <= NIL;
                    le_reg[o_reg]   <= EDGE_START;
                    ll_reg[o_reg]   <= '0;
                end
                S_WB:
                begin
                    lf_reg[l_reg] <= f_reg;
                    lz_reg[l_reg] <= z_reg;
                    lc_reg[l_reg] <= c_reg;
                    le_reg[l_reg] <= e_reg;
                    ll_reg[l_reg] <= len_reg;
                end
                default: ;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg <= s_tdata[3:0];
            l_reg   <= s_tdata[6:4];
            o_reg   <= s_tdata[9:7];
            v_reg   <= s_tdata[41:10];
            key_reg <= s_tdata[73:42];
            f_reg   <= lf_reg[row_addr];
            z_reg   <= lz_reg[row_addr];
            c_reg   <= lc_reg[row_addr];
            e_reg   <= le_reg[row_addr];
            len_reg <= ll_reg[row_addr];
        end
        if (state == S_OUT && out_free)
        begin
            md_reg[1:0]   <= st_reg;
            md_reg[33:2]  <= (st_reg == STAT_OK) ? item_reg : '0;
            md_reg[36:34] <= hd_reg;
            md_reg[43:37] <= (cmd_reg == CMD_CREATE || !open_reg[l_reg]) ? '0 : len_reg;
            md_reg[47:44] <= '0;
        end
        unique case (state)
            S_DEC:
            begin
                st_reg   <= STAT_OK;
                item_reg <= '0;
                hd_reg   <= '0;
            end
            S_BAD: st_reg <= STAT_FAIL;
            S_CREATE:
            begin
                if (any_free)
                    hd_reg <= free_list;
                else
                    st_reg <= STAT_FAIL;
            end
            S_FL:
            begin
                if (fl_n[IDX_W])
                begin
                    c_reg  <= NIL;
                    e_reg  <= (cmd_reg == CMD_FIRST) ? EDGE_START : EDGE_END;
                    st_reg <= STAT_NONE;
                end
                else
                begin
                    c_reg <= fl_n;
                    e_reg <= EDGE_INSIDE;
                end
            end
            S_VAL: item_reg <= v_rd;
            S_CUR: if (c_reg[IDX_W]) st_reg <= STAT_NONE;
            S_STEP0:
            begin
                if (f_reg[IDX_W])
                    st_reg <= STAT_NONE;
                else if (c_reg[IDX_W])
                begin
                    if (cmd_reg == CMD_NEXT && e_reg == EDGE_START)
                        n_reg <= f_reg;
                    else if (cmd_reg == CMD_PREV && e_reg == EDGE_END)
                        n_reg <= z_reg;
                    else
                        st_reg <= STAT_NONE;
                end
            end
            S_STEP1: n_reg <= (cmd_reg == CMD_NEXT) ? n_rd : p_rd;
            S_STEP2:
            begin
                if (n_reg[IDX_W])
                begin
                    c_reg  <= NIL;
                    e_reg  <= (cmd_reg == CMD_NEXT) ? EDGE_END : EDGE_START;
                    st_reg <= STAT_NONE;
                end
                else
                begin
                    c_reg <= n_reg;
                    e_reg <= EDGE_INSIDE;
                end
            end
            S_INS0:
            begin
                n_reg <= nn_reg;
                if (nn_reg[IDX_W])
                    st_reg <= STAT_FAIL;
                priority if (cmd_reg == CMD_APPEND)
                begin
                    a_reg <= z_reg; b_reg <= NIL;
                end
                else if (cmd_reg == CMD_PREPEND)
                begin
                    a_reg <= NIL; b_reg <= f_reg;
                end
                else if (!c_reg[IDX_W])
                begin
                    if (cmd_reg == CMD_INS_AFT)
                        a_reg <= c_reg;
                    else
                        b_reg <= c_reg;
                end
                else if (e_reg == EDGE_START)
                begin
                    a_reg <= NIL; b_reg <= f_reg;
                end
                else
                begin
                    a_reg <= z_reg; b_reg <= NIL;
                end
            end
            S_INS1:
            begin
                if (cmd_reg == CMD_INS_AFT)
                    b_reg <= n_rd;
                else
                    a_reg <= p_rd;
            end
            S_INS3:
            begin
                if (a_nil) f_reg <= n_reg;
                if (b_nil) z_reg <= n_reg;
                len_reg <= len_reg + 1'b1;
                c_reg   <= n_reg;
                e_reg   <= EDGE_INSIDE;
            end
            S_RM0:
            begin
                if (cmd_reg == CMD_REMOVE)
                begin
                    n_reg <= c_reg;
                    if (c_reg[IDX_W]) st_reg <= STAT_NONE;
                end
                else
                begin
                    n_reg <= z_reg;
                    if (z_reg[IDX_W]) st_reg <= STAT_NONE;
                end
            end
            S_RM1:
            begin
                item_reg <= v_rd;
                a_reg    <= p_rd;
                b_reg    <= n_rd;
            end
            S_RM2:
            begin
                f_reg   <= new_f;
                z_reg   <= new_z;
                len_reg <= len_reg - 1'b1;
                if (cmd_reg == CMD_REMOVE)
                begin
                    priority if (new_f[IDX_W])
                    begin
                        c_reg <= NIL; e_reg <= EDGE_START;
                    end
                    else if (b_nil)
                    begin
                        c_reg <= NIL; e_reg <= EDGE_END;
                    end
                    else
                        c_reg <= b_reg;
                end
                else
                begin
                    if (new_z[IDX_W])
                    begin
                        c_reg <= NIL; e_reg <= EDGE_END;
                    end
                    else
                    begin
                        c_reg <= new_z; e_reg <= EDGE_INSIDE;
                    end
                end
            end
            S_CAT0:
            begin
                if (flags.o_bad)
                    st_reg <= STAT_FAIL;
                of_reg   <= lf_reg[row_addr];
                oz_reg   <= lz_reg[row_addr];
                olen_reg <= ll_reg[row_addr];
            end
            S_CAT1:
            begin
                if (!of_reg[IDX_W])
                begin
                    if (z_reg[IDX_W]) f_reg <= of_reg;
                    z_reg   <= oz_reg;
                    len_reg <= len_reg + olen_reg;
                end
            end
            S_FR0: n_reg <= f_reg;
            S_FR2: n_reg <= n_rd;
            S_FR3:
            begin
                f_reg   <= NIL;
                z_reg   <= NIL;
                c_reg   <= NIL;
                e_reg   <= EDGE_START;
                len_reg <= '0;
            end
            S_SR0:
            begin
                if (!c_reg[IDX_W])
                    n_reg <= c_reg;
                else
                    n_reg <= (e_reg == EDGE_START) ? f_reg : NIL;
            end
            S_SR1:
            begin
                if (n_reg[IDX_W])
                begin
                    c_reg  <= NIL;
                    e_reg  <= EDGE_END;
                    st_reg <= STAT_NONE;
                end
            end
            S_SR2:
            begin
                if (v_rd == key_reg)
                begin
                    c_reg    <= n_reg;
                    e_reg    <= EDGE_INSIDE;
                    item_reg <= v_rd;
                end
                else
                    n_reg <= n_rd;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/pooled_cursor_list_manager.sv
// Top level of the pooled cursor list manager.
//
//  channel   dir  width  fields (low bit first)
//  s_axis    in   80     cmd, list_sel, other_list, item_value, search_key
//  m_axis    out  48     status, item_out, new_handle, item_count
//
// One command per transaction, one result transaction per command.
// Create, count and bad handles take the shortest path to m_tvalid; other commands
// take longer, and next, prev and insert at the cursor take the longest of the fixed paths.
// Free and search walk the list through the next-pointer memory, node by node.
// Reset clears all lists and node-busy marks at once; no clearing pass.
// A new command is taken while the previous result still waits on m_axis.
`timescale 1ns / 1ps
`default_nettype none
`include "pooled_cursor_list_manager_defines.svh"
module pooled_cursor_list_manager
    import plc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // cmd, list_sel, other_list, item_value, search_key
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata    // status, item_out, new_handle, item_count
);
    logic [SW-1:0] state;
    plc_flags_t    flags;

    plc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_fire(s_tvalid && s_tready),
        .flags(flags), .state(state)
    );

    plc_dp u_dp (
        .clk(clk), .rst_n(rst_n), .state(state),
        .s_tvalid(s_tvalid), .s_tdata(s_tdata), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .flags(flags)
    );

    `PLC_ASSERT_NEXT(a_one_cmd, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `PLC_ASSERT_NEXT(a_out_load, clk, rst_n, state == S_OUT && flags.out_free,
                     m_tvalid && state == S_IDLE)
    `PLC_ASSERT_SAME(a_no_item, clk, rst_n, m_tvalid && m_tdata[1:0] != STAT_OK,
                     m_tdata[33:2] == '0)
endmodule
`default_nettype wire
